>>> design/i2cbb_pkg.sv
// ---------------------------------------------------------------------------
// i2cbb_pkg: shared types and constants of the I2C bit-bang master
// Operation codes, status codes, the queued command and the queue depth.
// ---------------------------------------------------------------------------
package i2cbb_pkg;

   // bus operation carried by one item
   typedef enum logic [1:0] {
      FUNC_START_ADDR = 2'd0,
      FUNC_WRITE      = 2'd1,
      FUNC_READ       = 2'd2,
      FUNC_STOP       = 2'd3
   } func_type;

   // closing status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NACK    = 2'd1;
   localparam logic [1:0] STATUS_ABORTED = 2'd2;

   // configuration register indexes and reset values
   localparam int unsigned CSR_ADDR_W       = 3;
   localparam logic [0:0]  CSR_HALF_PERIOD  = 1'b0;
   localparam logic [15:0] HALF_PERIOD_RST  = 16'd100;

   // command queue between front and back
   localparam int unsigned QUEUE_DEPTH_DEF = 2;

   // classified command handed from front to back
   typedef struct packed {
      func_type    op;
      logic [7:0]  tx_byte;
      logic        master_ack;
      logic [8:0]  bus_sda;
   } cmd_type;

endpackage

>>> design/i2cbb_front.sv
// ---------------------------------------------------------------------------
// i2cbb_front: input item decoder
// Accepts request items and turns them into queued bus commands.
// ---------------------------------------------------------------------------
module i2cbb_front
   import i2cbb_pkg::*;
(
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_func,
   input  logic [6:0] req_address,
   input  logic       req_read_bit,
   input  logic [7:0] req_data,
   input  logic       req_master_ack,
   input  logic [8:0] req_bus_sda,
   output logic       push_valid,
   input  logic       push_ready,
   output cmd_type    push_cmd
);

   func_type op;

   // decode operation and pick the byte that goes out on the bus
   always_comb begin
      op                  = func_type'(req_func);
      push_cmd.op         = op;
      push_cmd.tx_byte    = (op == FUNC_START_ADDR) ? {req_address, req_read_bit} : req_data;
      push_cmd.master_ack = req_master_ack;
      push_cmd.bus_sda    = req_bus_sda;
   end

   assign push_valid = req_valid;
   assign req_ready  = push_ready;

endmodule

>>> design/i2cbb_queue.sv
// ---------------------------------------------------------------------------
// i2cbb_queue: small command FIFO
// Decouples item intake from the phase sequencer.
// ---------------------------------------------------------------------------
module i2cbb_queue #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> design/i2cbb_back.sv
// ---------------------------------------------------------------------------
// i2cbb_back: pin phase sequencer
// Steps through start, byte, read and stop sequences, one phase per cycle while
// the output register is free, and closes each command with a status result.
// ---------------------------------------------------------------------------
module i2cbb_back
   import i2cbb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] half_period,
   input  logic        cmd_valid,
   input  cmd_type     cmd,
   output logic        cmd_pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_scl,
   output logic        rsp_sda,
   output logic [15:0] rsp_wait_cycles,
   output logic        rsp_is_status,
   output logic [7:0]  rsp_read_data,
   output logic [1:0]  rsp_status,
   output logic        rsp_last
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_START  = 6'b000010,
      ST_TX     = 6'b000100,
      ST_RX     = 6'b001000,
      ST_STOP   = 6'b010000,
      ST_STATUS = 6'b100000
   } state_type;

   state_type   state_ff, state_in;
   logic [4:0]  step_ff, step_in;
   logic [1:0]  sub_ff, sub_in;
   logic [7:0]  shift_ff, shift_in;
   logic        ack_ff, ack_in;
   logic        nack_smp_ff, nack_smp_in;
   logic [7:0]  rd_ff, rd_in;
   logic [1:0]  st_ff, st_in;
   logic        aborted_ff, aborted_in;
   logic        scl_ff, scl_in;
   logic        sda_ff, sda_in;

   logic        out_valid_ff, out_valid_in;
   logic        out_scl_ff, out_sda_ff, out_is_status_ff, out_last_ff;
   logic [15:0] out_wait_ff;
   logic [7:0]  out_rd_ff;
   logic [1:0]  out_st_ff;

   logic        out_free;
   logic        emit_phase, emit_status;
   logic        ph_scl, ph_level, ph_delay;
   logic        dispatch;

   assign out_free = !out_valid_ff || rsp_ready;

   // sequencer: phase selection and next state
   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      sub_in      = sub_ff;
      shift_in    = shift_ff;
      ack_in      = ack_ff;
      nack_smp_in = nack_smp_ff;
      rd_in       = rd_ff;
      st_in       = st_ff;
      aborted_in  = aborted_ff;
      emit_phase  = 1'b0;
      emit_status = 1'b0;
      ph_scl      = 1'b0;
      ph_level    = 1'b1;
      ph_delay    = 1'b0;
      dispatch    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            dispatch = 1'b1;
         end
         ST_START: begin
            if (out_free) begin
               emit_phase = 1'b1;
               step_in    = step_ff + 5'd1;
               case (step_ff[1:0])
                  2'd0: begin ph_scl = 1'b0; ph_level = 1'b1; ph_delay = 1'b0; end
                  2'd1: begin ph_scl = 1'b1; ph_level = 1'b1; ph_delay = 1'b1; end
                  2'd2: begin ph_scl = 1'b0; ph_level = 1'b0; ph_delay = 1'b1; end
                  default: begin
                     ph_scl   = 1'b1;
                     ph_level = 1'b0;
                     ph_delay = 1'b0;
                     state_in = ST_TX;
                     step_in  = '0;
                     sub_in   = '0;
                  end
               endcase
            end
         end
         ST_TX: begin
            if (out_free) begin
               emit_phase = 1'b1;
               sub_in     = sub_ff + 2'd1;
               case (sub_ff)
                  2'd0: begin
                     // data bit, or released SDA for the ack slot
                     ph_scl   = 1'b0;
                     ph_level = (step_ff == 5'd8) ? 1'b1 : shift_ff[7];
                     ph_delay = 1'b1;
                  end
                  2'd1: begin ph_scl = 1'b1; ph_level = 1'b1; ph_delay = 1'b1; end
                  default: begin
                     ph_scl   = 1'b1;
                     ph_level = 1'b0;
                     ph_delay = 1'b0;
                     sub_in   = '0;
                     step_in  = step_ff + 5'd1;
                     shift_in = {shift_ff[6:0], 1'b0};
                     if (step_ff == 5'd8) begin
                        step_in = '0;
                        if (nack_smp_ff) begin
                           st_in      = STATUS_NACK;
                           aborted_in = 1'b1;
                           state_in   = ST_STOP;
                        end else begin
                           state_in = ST_STATUS;
                        end
                     end
                  end
               endcase
            end
         end
         ST_RX: begin
            if (out_free) begin
               emit_phase = 1'b1;
               step_in    = step_ff + 5'd1;
               if (step_ff == 5'd0) begin
                  ph_scl = 1'b0; ph_level = 1'b1; ph_delay = 1'b0;
               end else if (step_ff <= 5'd16) begin
                  // eight SCL pulses for the data bits, both edges delayed
                  ph_scl = 1'b1; ph_level = step_ff[0]; ph_delay = 1'b1;
               end else if (step_ff == 5'd17) begin
                  ph_scl = 1'b0; ph_level = !ack_ff; ph_delay = 1'b1;
               end else if (step_ff == 5'd18) begin
                  ph_scl = 1'b1; ph_level = 1'b1; ph_delay = 1'b1;
               end else if (step_ff == 5'd19) begin
                  ph_scl = 1'b1; ph_level = 1'b0; ph_delay = 1'b0;
               end else begin
                  ph_scl   = 1'b0;
                  ph_level = 1'b1;
                  ph_delay = 1'b0;
                  state_in = ST_STATUS;
                  step_in  = '0;
               end
            end
         end
         ST_STOP: begin
            if (out_free) begin
               emit_phase = 1'b1;
               step_in    = step_ff + 5'd1;
               ph_delay   = 1'b1;
               case (step_ff[1:0])
                  2'd0: begin ph_scl = 1'b0; ph_level = 1'b0; end
                  2'd1: begin ph_scl = 1'b1; ph_level = 1'b1; end
                  default: begin
                     ph_scl   = 1'b0;
                     ph_level = 1'b1;
                     state_in = ST_STATUS;
                     step_in  = '0;
                  end
               endcase
            end
         end
         ST_STATUS: begin
            if (out_free) begin
               emit_status = 1'b1;
               dispatch    = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // take the next command, or go idle
      if (dispatch) begin
         state_in = ST_IDLE;
         if (cmd_valid) begin
            step_in     = '0;
            sub_in      = '0;
            shift_in    = cmd.tx_byte;
            ack_in      = cmd.master_ack;
            nack_smp_in = cmd.bus_sda[0];
            rd_in       = '0;
            st_in       = STATUS_OK;
            if (aborted_ff) begin
               // ignored item, a stop clears the abort mark
               state_in = ST_STATUS;
               st_in    = STATUS_ABORTED;
               if (cmd.op == FUNC_STOP) begin
                  aborted_in = 1'b0;
               end
            end else begin
               unique case (cmd.op)
                  FUNC_START_ADDR: state_in = ST_START;
                  FUNC_WRITE:      state_in = ST_TX;
                  FUNC_READ: begin
                     state_in = ST_RX;
                     rd_in    = cmd.bus_sda[8:1];
                  end
                  FUNC_STOP:       state_in = ST_STOP;
                  default:         state_in = ST_IDLE;
               endcase
            end
         end
      end

      // pin levels
      scl_in = scl_ff;
      sda_in = sda_ff;
      if (emit_phase) begin
         if (ph_scl) begin
            scl_in = ph_level;
         end else begin
            sda_in = ph_level;
         end
      end
   end

   assign cmd_pop = dispatch && cmd_valid;

   // output register valid
   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit_phase || emit_status) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         aborted_ff   <= 1'b0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         out_valid_ff <= 1'b0;
         step_ff      <= '0;
         sub_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         aborted_ff   <= aborted_in;
         scl_ff       <= scl_in;
         sda_ff       <= sda_in;
         out_valid_ff <= out_valid_in;
         step_ff      <= step_in;
         sub_ff       <= sub_in;
      end
   end

   // command payload
   always_ff @(posedge clock) begin
      shift_ff    <= shift_in;
      ack_ff      <= ack_in;
      nack_smp_ff <= nack_smp_in;
      rd_ff       <= rd_in;
      st_ff       <= st_in;
   end

   // result payload
   always_ff @(posedge clock) begin
      if (emit_phase) begin
         out_scl_ff       <= scl_in;
         out_sda_ff       <= sda_in;
         out_wait_ff      <= ph_delay ? half_period : 16'd0;
         out_is_status_ff <= 1'b0;
         out_rd_ff        <= '0;
         out_st_ff        <= STATUS_OK;
         out_last_ff      <= 1'b0;
      end else if (emit_status) begin
         out_scl_ff       <= scl_ff;
         out_sda_ff       <= sda_ff;
         out_wait_ff      <= 16'd0;
         out_is_status_ff <= 1'b1;
         out_rd_ff        <= rd_ff;
         out_st_ff        <= st_ff;
         out_last_ff      <= 1'b1;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_scl         = out_scl_ff;
   assign rsp_sda         = out_sda_ff;
   assign rsp_wait_cycles = out_wait_ff;
   assign rsp_is_status   = out_is_status_ff;
   assign rsp_read_data   = out_rd_ff;
   assign rsp_status      = out_st_ff;
   assign rsp_last        = out_last_ff;

endmodule

>>> design/i2c_bitbang_master.sv
// ---------------------------------------------------------------------------
// i2c_bitbang_master: I2C master, one bus operation per item
// Usage:
//   req_* carries one operation (start plus address, write, read, stop)
//   together with the sampled SDA levels of its slots. rsp_* returns a run of
//   pin phases (SCL, SDA, hold cycles) closed by one status result with
//   rsp_last set. csr_* is an APB-style port holding half_period_cycles at
//   byte address 0.
// Throughput: one result per cycle while the receiver is ready and a command
//   is in progress. A start makes 31 phases, a write 27, a read 21, a stop 3,
//   each plus the status; a missing acknowledge adds a 3 phase stop. The back
//   sequencer emitting one phase per cycle sets the rate.
// Order: an accepted item passes the queue, the back sequencer state and the
//   output register; following items start right after the previous status.
// Reset: SCL and SDA levels high, abort mark clear, queue empty,
//   half_period_cycles 100.
// Stall: a stalled receiver holds the output register; the command queue
//   keeps taking items until it is full, then req_ready falls.
// ---------------------------------------------------------------------------
module i2c_bitbang_master
   import i2cbb_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_func,
   input  logic [6:0]            req_address,
   input  logic                  req_read_bit,
   input  logic [7:0]            req_data,
   input  logic                  req_master_ack,
   input  logic [8:0]            req_bus_sda,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_scl,
   output logic                  rsp_sda,
   output logic [15:0]           rsp_wait_cycles,
   output logic                  rsp_is_status,
   output logic [7:0]            rsp_read_data,
   output logic [1:0]            rsp_status,
   output logic                  rsp_last,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [15:0] half_period_ff, half_period_in;
   logic        push_valid, push_ready;
   cmd_type     push_cmd;
   logic        pop_valid, pop;
   cmd_type     pop_cmd;
   logic        csr_hit;

   // configuration register
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1] == CSR_HALF_PERIOD);

   always_comb begin
      half_period_in = half_period_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_hit) begin
         half_period_in = csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= HALF_PERIOD_RST;
      end else begin
         half_period_ff <= half_period_in;
      end
   end

   assign csr_prdata = csr_hit ? {16'd0, half_period_ff} : 32'd0;

   // intake
   i2cbb_front u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_address    (req_address),
      .req_read_bit   (req_read_bit),
      .req_data       (req_data),
      .req_master_ack (req_master_ack),
      .req_bus_sda    (req_bus_sda),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_cmd       (push_cmd)
   );

   // command queue
   i2cbb_queue #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_cmd),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_data   (pop_cmd)
   );

   // phase sequencer
   i2cbb_back u_back (
      .clock           (clock),
      .reset           (reset),
      .half_period     (half_period_ff),
      .cmd_valid       (pop_valid),
      .cmd             (pop_cmd),
      .cmd_pop         (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_scl         (rsp_scl),
      .rsp_sda         (rsp_sda),
      .rsp_wait_cycles (rsp_wait_cycles),
      .rsp_is_status   (rsp_is_status),
      .rsp_read_data   (rsp_read_data),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last)
   );

endmodule
